// File: hdl/fdm_pkg.sv
// ----------------------------------------------------------------------------
// FAT directory name matcher package
// Shared widths, stream field offsets, the item mode codes, the structs that
// pass between the pipeline stages, and the small byte and checksum helpers.
// ----------------------------------------------------------------------------
package fdm_pkg;

   // Directory entry and field widths.
   localparam int ENTRY_W    = 256;
   localparam int WORD_W     = 64;
   localparam int BYTE_W     = 8;
   localparam int MODE_W     = 2;
   localparam int SLOT_W     = 5;
   localparam int IDX_W      = 6;
   localparam int COUNT_W    = 6;
   localparam int CLUSTER_W  = 32;

   // Entry layout.
   localparam int NAME_LEN       = 11;
   localparam int SUM_SPLIT      = 6;
   localparam int ATTR_BYTE      = 11;
   localparam int CHECKSUM_BYTE  = 13;
   localparam logic [BYTE_W-1:0] LONG_ATTR = 8'h0F;

   // Request stream packing: slot, then the four entry words, padded to bytes.
   localparam int REQ_SLOT_LSB  = 0;
   localparam int REQ_ENTRY_LSB = REQ_SLOT_LSB + SLOT_W;
   localparam int REQ_USED_W    = REQ_ENTRY_LSB + ENTRY_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // Response stream packing: found, start cluster, progress, padded to bytes.
   localparam int RSP_USED_W  = 1 + CLUSTER_W + IDX_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_LONG_COUNT_IDX = 1'b0;

   // Item modes carried on tuser.
   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_SCAN  = 2'd2
   } mode_type;

   // Item held in the compare stage.
   typedef struct packed {
      mode_type              mode;
      logic [ENTRY_W-1:0]    entry;
      logic [BYTE_W-1:0]     sum_part;
   } item_type;

   // Result of one item.
   typedef struct packed {
      logic                  found;
      logic [CLUSTER_W-1:0]  cluster;
      logic [IDX_W-1:0]      progress;
   } result_type;

   // Byte k of a little-endian entry.
   function automatic logic [BYTE_W-1:0] entry_byte(input logic [ENTRY_W-1:0] e,
                                                    input int k);
      return e[k*BYTE_W +: BYTE_W];
   endfunction

   // One step of the short-name checksum: rotate right by one, then add.
   function automatic logic [BYTE_W-1:0] name_sum_step(input logic [BYTE_W-1:0] s,
                                                       input logic [BYTE_W-1:0] b);
      return {s[0], s[BYTE_W-1:1]} + b;
   endfunction

endpackage

// File: hdl/fdm_target_ram.sv
// ----------------------------------------------------------------------------
// FAT directory name matcher target RAM
// Holds the prebuilt target entries, one per slot. One write port and two
// registered read ports.
// ----------------------------------------------------------------------------
module fdm_target_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [fdm_pkg::ENTRY_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr_a,
   input  logic [ADDR_W-1:0]           rd_addr_b,
   output logic [fdm_pkg::ENTRY_W-1:0] rd_data_a,
   output logic [fdm_pkg::ENTRY_W-1:0] rd_data_b
);

   logic [fdm_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [fdm_pkg::ENTRY_W-1:0] rd_data_a_ff;
   logic [fdm_pkg::ENTRY_W-1:0] rd_data_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: hdl/fdm_match_engine.sv
// ----------------------------------------------------------------------------
// FAT directory name matcher compare stage
// Compares the item in the second stage against the target read from RAM,
// finishes the short-name checksum, and keeps the match index and the saved
// long-entry checksum. Also forms the speculative read slot for the next item.
// ----------------------------------------------------------------------------
module fdm_match_engine #(
   parameter int MAX_TARGETS = 32,
   parameter int ADDR_W      = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  logic                          advance,
   input  fdm_pkg::item_type             item,
   input  logic [fdm_pkg::COUNT_W-1:0]   long_count,
   input  logic [fdm_pkg::ENTRY_W-1:0]   rd_data_a,
   input  logic [fdm_pkg::ENTRY_W-1:0]   rd_data_b,
   output logic [ADDR_W-1:0]             spec_addr,
   output fdm_pkg::result_type           result
);

   localparam int CNT_W = fdm_pkg::IDX_W + 1;
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_TARGETS);

   logic [fdm_pkg::IDX_W-1:0]   match_index_ff;
   logic [fdm_pkg::IDX_W-1:0]   match_index_in;
   logic [fdm_pkg::BYTE_W-1:0]  saved_checksum_ff;
   logic [fdm_pkg::BYTE_W-1:0]  saved_checksum_in;

   logic [CNT_W-1:0]            count_ext;
   logic [CNT_W-1:0]            target_count;
   logic                        short_mode;
   logic                        long_phase;
   logic [fdm_pkg::ENTRY_W-1:0] target;
   logic                        e_long;
   logic                        t_long;
   logic                        name_eq;
   logic                        frag_eq;
   logic                        entries_match;
   logic [fdm_pkg::BYTE_W-1:0]  name_sum;
   logic [fdm_pkg::BYTE_W-1:0]  checksum_ref;
   logic [fdm_pkg::IDX_W-1:0]   index_after;
   logic                        found;
   logic [fdm_pkg::IDX_W-1:0]   spec_index;
   logic [CNT_W-1:0]            spec_index_ext;

   // Effective number of long targets, held to the store depth.
   assign count_ext    = CNT_W'(long_count);
   assign target_count = (count_ext > MAX_COUNT) ? MAX_COUNT : count_ext;
   assign short_mode   = (target_count == '0);
   assign long_phase   = !short_mode && ({1'b0, match_index_ff} < target_count);

   // Port B always reads slot zero; port A reads the slot the index points at.
   assign target = (short_mode || match_index_ff == '0) ? rd_data_b : rd_data_a;

   // Entry class and field comparisons.
   always_comb begin
      e_long  = (fdm_pkg::entry_byte(item.entry, fdm_pkg::ATTR_BYTE) == fdm_pkg::LONG_ATTR);
      t_long  = (fdm_pkg::entry_byte(target, fdm_pkg::ATTR_BYTE) == fdm_pkg::LONG_ATTR);
      name_eq = 1'b1;
      for (int k = 0; k < fdm_pkg::NAME_LEN; k++) begin
         if (fdm_pkg::entry_byte(item.entry, k) != fdm_pkg::entry_byte(target, k)) begin
            name_eq = 1'b0;
         end
      end
      frag_eq = 1'b1;
      for (int k = 14; k < 26; k++) begin
         if (fdm_pkg::entry_byte(item.entry, k) != fdm_pkg::entry_byte(target, k)) begin
            frag_eq = 1'b0;
         end
      end
      for (int k = 28; k < 32; k++) begin
         if (fdm_pkg::entry_byte(item.entry, k) != fdm_pkg::entry_byte(target, k)) begin
            frag_eq = 1'b0;
         end
      end
      entries_match = (e_long == t_long) && name_eq && (!e_long || frag_eq);
   end

   // Finish the short-name checksum over the remaining name bytes.
   always_comb begin
      name_sum = item.sum_part;
      for (int k = fdm_pkg::SUM_SPLIT; k < fdm_pkg::NAME_LEN; k++) begin
         name_sum = fdm_pkg::name_sum_step(name_sum, fdm_pkg::entry_byte(item.entry, k));
      end
   end

   // A long entry updates the saved checksum before the checksum compare.
   assign checksum_ref = e_long ? fdm_pkg::entry_byte(item.entry, fdm_pkg::CHECKSUM_BYTE)
                                : saved_checksum_ff;

   // Next match state and the hit decision.
   always_comb begin
      index_after       = match_index_ff;
      saved_checksum_in = saved_checksum_ff;
      found             = 1'b0;
      if (item_valid) begin
         unique case (item.mode)
            fdm_pkg::MODE_CLEAR: begin
               index_after       = '0;
               saved_checksum_in = '0;
            end
            fdm_pkg::MODE_LOAD: begin
               index_after = match_index_ff;
            end
            fdm_pkg::MODE_SCAN: begin
               if (e_long) begin
                  saved_checksum_in = fdm_pkg::entry_byte(item.entry,
                                                          fdm_pkg::CHECKSUM_BYTE);
               end
               if (short_mode) begin
                  found       = entries_match;
                  index_after = entries_match ? fdm_pkg::IDX_W'(1) : '0;
               end else if (long_phase) begin
                  index_after = entries_match ? match_index_ff + 1'b1 : '0;
               end else begin
                  found       = (name_sum == checksum_ref);
                  index_after = found ? match_index_ff : '0;
               end
            end
            default: begin
               index_after = match_index_ff;
            end
         endcase
      end
      match_index_in = found ? '0 : index_after;
   end

   // Result fields.
   always_comb begin
      result.found    = found;
      result.progress = index_after;
      result.cluster  = found ? {fdm_pkg::entry_byte(item.entry, 21),
                                 fdm_pkg::entry_byte(item.entry, 20),
                                 fdm_pkg::entry_byte(item.entry, 27),
                                 fdm_pkg::entry_byte(item.entry, 26)} : '0;
   end

   // The next item reads the slot after this one on a long match; any other
   // scan outcome lands on slot zero, which port B covers.
   always_comb begin
      if (item_valid && item.mode == fdm_pkg::MODE_SCAN && long_phase) begin
         spec_index = match_index_ff + 1'b1;
      end else begin
         spec_index = match_index_ff;
      end
      spec_index_ext = CNT_W'(spec_index);
      spec_addr      = (spec_index_ext >= MAX_COUNT) ? '0 : ADDR_W'(spec_index);
   end

   // Search state.
   always_ff @(posedge clock) begin
      if (reset) begin
         match_index_ff    <= '0;
         saved_checksum_ff <= '0;
      end else if (advance) begin
         match_index_ff    <= match_index_in;
         saved_checksum_ff <= saved_checksum_in;
      end
   end

endmodule

// File: hdl/fat_directory_name_matcher.sv
// ----------------------------------------------------------------------------
// FAT directory name matcher
// Scans a stream of FAT directory entries for a long or short target name.
// ----------------------------------------------------------------------------
// Usage:
//   Each req transaction carries a mode on req_tuser and a slot plus one
//   32-byte directory entry on req_tdata. Load transactions write the entry
//   into a target slot, clear transactions restart the search, and scan
//   transactions compare the entry against the next expected target. Every
//   request yields exactly one rsp transaction with the hit flag, the start
//   cluster of the hit entry and the number of targets matched so far.
//   The long_entry_count register (APB, byte address 0) sets how many long
//   targets are expected; zero selects a short-name compare against slot 0.
//   Throughput is one transaction per cycle while rsp_tready stays high.
//   The target RAM is read at acceptance, and the compare stage then fills
//   the output register. Two RAM read ports (the next slot and slot 0)
//   let the following entry be read before the current compare resolves.
//   Reset clears the search state, the register and the pipeline; the target
//   RAM is not cleared and must be loaded before use. When rsp_tready is low
//   the output register holds, one more request is taken into the compare
//   stage, and then req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module fat_directory_name_matcher #(
   parameter int MAX_TARGETS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: slot, entry_word0, entry_word1, entry_word2,
   // entry_word3, zero padding.
   input  logic [fdm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // Fields from bit 0: mode.
   input  logic [fdm_pkg::MODE_W-1:0]        req_tuser,
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: found, first_cluster, match_progress, zero padding.
   output logic [fdm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fdm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fdm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fdm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int ADDR_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam logic [fdm_pkg::IDX_W:0] MAX_SLOTS = (fdm_pkg::IDX_W + 1)'(MAX_TARGETS);
   localparam int CSR_IDX_W = fdm_pkg::CSR_ADDR_W - 2;

   logic                            req_accept;
   logic                            advance;
   fdm_pkg::mode_type               req_mode;
   logic [fdm_pkg::SLOT_W-1:0]      req_slot;
   logic [fdm_pkg::ENTRY_W-1:0]     req_entry;
   logic [fdm_pkg::BYTE_W-1:0]      req_sum_part;
   logic                            load_en;

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   fdm_pkg::item_type               s1_item_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   fdm_pkg::result_type             rsp_result_ff;
   fdm_pkg::result_type             result;

   logic [fdm_pkg::COUNT_W-1:0]     long_count_ff;
   logic [fdm_pkg::COUNT_W-1:0]     long_count_in;
   logic                            csr_write;
   logic                            csr_hit;

   logic [ADDR_W-1:0]               spec_addr;
   logic [fdm_pkg::ENTRY_W-1:0]     rd_data_a;
   logic [fdm_pkg::ENTRY_W-1:0]     rd_data_b;

   // Handshake: the compare stage moves on when the output register is free.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Request field unpacking.
   assign req_mode  = fdm_pkg::mode_type'(req_tuser);
   assign req_slot  = req_tdata[fdm_pkg::REQ_SLOT_LSB +: fdm_pkg::SLOT_W];
   assign req_entry = req_tdata[fdm_pkg::REQ_ENTRY_LSB +: fdm_pkg::ENTRY_W];

   // First half of the short-name checksum, taken at acceptance.
   always_comb begin
      req_sum_part = '0;
      for (int k = 0; k < fdm_pkg::SUM_SPLIT; k++) begin
         req_sum_part = fdm_pkg::name_sum_step(req_sum_part,
                                               fdm_pkg::entry_byte(req_entry, k));
      end
   end

   // Loads go straight into the RAM; slots beyond the store are dropped.
   assign load_en = req_accept && (req_mode == fdm_pkg::MODE_LOAD) &&
                    ({2'b00, req_slot} < MAX_SLOTS);

   fdm_target_ram #(
      .DEPTH  (MAX_TARGETS),
      .ADDR_W (ADDR_W)
   ) u_target_ram (
      .clock     (clock),
      .wr_en     (load_en),
      .wr_addr   (ADDR_W'(req_slot)),
      .wr_data   (req_entry),
      .rd_en     (req_accept),
      .rd_addr_a (spec_addr),
      .rd_addr_b ('0),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Compare stage register.
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.mode     <= req_mode;
         s1_item_ff.entry    <= req_entry;
         s1_item_ff.sum_part <= req_sum_part;
      end
   end

   fdm_match_engine #(
      .MAX_TARGETS (MAX_TARGETS),
      .ADDR_W      (ADDR_W)
   ) u_match_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .advance    (advance),
      .item       (s1_item_ff),
      .long_count (long_count_ff),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .spec_addr  (spec_addr),
      .result     (result)
   );

   // Output register.
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = fdm_pkg::RSP_TDATA_W'({rsp_result_ff.progress,
                                              rsp_result_ff.cluster,
                                              rsp_result_ff.found});

   // Register port: single register, written on the access phase.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[fdm_pkg::CSR_ADDR_W-1:2] ==
                        CSR_IDX_W'(fdm_pkg::CSR_LONG_COUNT_IDX));
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;

   assign long_count_in = csr_write ? csr_pwdata[fdm_pkg::COUNT_W-1:0] : long_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_count_ff <= '0;
      end else begin
         long_count_ff <= long_count_in;
      end
   end

   assign csr_prdata = csr_hit ? fdm_pkg::CSR_DATA_W'(long_count_ff) : '0;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// FAT directory name matcher testbench
// Loads target slots, scans directed and random directory entries through the
// request stream, and checks every response against a cycle-free predictor of
// the search state. Random chains of matching entries are built from the
// loaded targets so that long and short name hits are reached often, with
// spoiled chains and noise in between. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int SLOT_COUNT   = 32;
   localparam int HALF_PERIOD  = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int SEGMENTS     = 14;
   localparam int SEGMENT_SIZE = 90;
   localparam int TIMEOUT      = 4000000;

   // Widths and layout taken from the package.
   localparam int ENTRY_W       = fdm_pkg::ENTRY_W;
   localparam int BYTE_W        = fdm_pkg::BYTE_W;
   localparam int MODE_W        = fdm_pkg::MODE_W;
   localparam int SLOT_W        = fdm_pkg::SLOT_W;
   localparam int IDX_W         = fdm_pkg::IDX_W;
   localparam int COUNT_W       = fdm_pkg::COUNT_W;
   localparam int CLUSTER_W     = fdm_pkg::CLUSTER_W;
   localparam int NAME_LEN      = fdm_pkg::NAME_LEN;
   localparam int ATTR_BYTE     = fdm_pkg::ATTR_BYTE;
   localparam int CHECKSUM_BYTE = fdm_pkg::CHECKSUM_BYTE;
   localparam int REQ_TDATA_W   = fdm_pkg::REQ_TDATA_W;
   localparam int REQ_SLOT_LSB  = fdm_pkg::REQ_SLOT_LSB;
   localparam int REQ_ENTRY_LSB = fdm_pkg::REQ_ENTRY_LSB;
   localparam int RSP_TDATA_W   = fdm_pkg::RSP_TDATA_W;
   localparam int CSR_ADDR_W    = fdm_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W    = fdm_pkg::CSR_DATA_W;
   localparam logic [BYTE_W-1:0] LONG_ATTR = fdm_pkg::LONG_ATTR;

   // Mode code that the block leaves without effect.
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

   // Directory entry layout beyond the package constants.
   localparam int FRAG2_FIRST     = 14;
   localparam int FRAG2_END       = 26;
   localparam int FRAG3_FIRST     = 28;
   localparam int ENTRY_BYTES     = 32;
   localparam int CLUSTER_HI_BYTE = 20;
   localparam int CLUSTER_LO_BYTE = 26;
   localparam logic [BYTE_W-1:0] SHORT_ATTR = 8'h20;

   // Response field positions.
   localparam int RSP_FOUND_BIT    = 0;
   localparam int RSP_CLUSTER_LSB  = 1;
   localparam int RSP_PROGRESS_LSB = RSP_CLUSTER_LSB + CLUSTER_W;

   localparam logic [CSR_ADDR_W-1:0] LONG_COUNT_ADDR =
      CSR_ADDR_W'(4 * int'(fdm_pkg::CSR_LONG_COUNT_IDX));

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_W-1:0]    req_tdata = '0;
   logic [MODE_W-1:0]         req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   // Generator view of the slot contents and the register.
   logic [ENTRY_W-1:0]        target_image [SLOT_COUNT];
   logic [COUNT_W-1:0]        cur_count = '0;
   int                        item_count = 0;
   int                        send_idle_pct = 0;
   int                        stall_pct = 0;

   fat_directory_name_matcher #(.MAX_TARGETS(SLOT_COUNT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Byte k of a little-endian entry, and the entry with byte k replaced.
   function automatic logic [BYTE_W-1:0] octet(input logic [ENTRY_W-1:0] e, input int k);
      return e[k*BYTE_W +: BYTE_W];
   endfunction

   function automatic logic [ENTRY_W-1:0] put_octet(input logic [ENTRY_W-1:0] e,
                                                    input int k,
                                                    input logic [BYTE_W-1:0] v);
      e[k*BYTE_W +: BYTE_W] = v;
      return e;
   endfunction

   // True when byte k takes part in the name compare of a short or long entry.
   function automatic bit name_byte(input int k, input bit is_long);
      return k < NAME_LEN ||
             (is_long && ((k >= FRAG2_FIRST && k < FRAG2_END) || k >= FRAG3_FIRST));
   endfunction

   function automatic bit is_long_entry(input logic [ENTRY_W-1:0] e);
      return octet(e, ATTR_BYTE) == LONG_ATTR;
   endfunction

   // Rotate-right-and-add checksum over the 11 short-name bytes.
   function automatic logic [BYTE_W-1:0] short_name_sum(input logic [ENTRY_W-1:0] e);
      logic [BYTE_W-1:0] s;
      s = '0;
      for (int k = 0; k < NAME_LEN; k++)
         s = {s[0], s[BYTE_W-1:1]} + octet(e, k);
      return s;
   endfunction

   // Class and name compare of a target against a scanned entry.
   function automatic bit names_agree(input logic [ENTRY_W-1:0] t,
                                      input logic [ENTRY_W-1:0] e);
      bit e_long;
      e_long = is_long_entry(e);
      if (is_long_entry(t) != e_long)
         return 1'b0;
      for (int k = 0; k < ENTRY_BYTES; k++)
         if (name_byte(k, e_long) && octet(t, k) != octet(e, k))
            return 1'b0;
      return 1'b1;
   endfunction

   // Scoreboard: tracks slots, match index and saved checksum, and holds the
   // responses still owed by the block.
   class match_scoreboard;
      logic [ENTRY_W-1:0]   slots [SLOT_COUNT];
      logic [IDX_W-1:0]     matched;
      logic [BYTE_W-1:0]    saved_sum;
      logic [COUNT_W-1:0]   long_count;
      fdm_pkg::result_type  owed_results [$];
      int                   errors;

      function new();
         matched    = '0;
         saved_sum  = '0;
         long_count = '0;
         errors     = 0;
         foreach (slots[i])
            slots[i] = '0;
      endfunction

      function void set_long_count(input logic [COUNT_W-1:0] value);
         long_count = value;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      task report(input string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      // Advance the search state by one accepted request and queue its response.
      function void note_request(input logic [MODE_W-1:0] mode,
                                 input logic [SLOT_W-1:0] slot,
                                 input logic [ENTRY_W-1:0] entry);
         fdm_pkg::result_type r;
         int lim;
         bit hit;
         r   = '0;
         hit = 1'b0;
         lim = (int'(long_count) > SLOT_COUNT) ? SLOT_COUNT : int'(long_count);
         case (mode)
            fdm_pkg::MODE_CLEAR: begin
               matched   = '0;
               saved_sum = '0;
            end
            fdm_pkg::MODE_LOAD: begin
               slots[slot] = entry;
            end
            fdm_pkg::MODE_SCAN: begin
               if (is_long_entry(entry))
                  saved_sum = octet(entry, CHECKSUM_BYTE);
               if (lim == 0) begin
                  hit     = names_agree(slots[0], entry);
                  matched = hit ? IDX_W'(1) : '0;
               end else if (int'(matched) < lim) begin
                  if (names_agree(slots[int'(matched) % SLOT_COUNT], entry))
                     matched = matched + 1'b1;
                  else
                     matched = '0;
               end else if (short_name_sum(entry) == saved_sum) begin
                  hit = 1'b1;
               end else begin
                  matched = '0;
               end
               if (hit)
                  r.cluster = {octet(entry, CLUSTER_HI_BYTE + 1), octet(entry, CLUSTER_HI_BYTE),
                               octet(entry, CLUSTER_LO_BYTE + 1), octet(entry, CLUSTER_LO_BYTE)};
            end
            default: ;
         endcase
         r.found    = hit;
         r.progress = matched;
         if (hit)
            matched = '0;
         owed_results.push_back(r);
      endfunction

      // Compare one accepted response with the oldest one owed.
      task check_result(input logic [RSP_TDATA_W-1:0] d);
         fdm_pkg::result_type want;
         if (owed_results.size() == 0) begin
            report($sformatf("response %h with none outstanding", d));
            return;
         end
         want = owed_results.pop_front();
         if (d[RSP_FOUND_BIT] !== want.found)
            report($sformatf("found %b, predicted %b", d[RSP_FOUND_BIT], want.found));
         if (d[RSP_CLUSTER_LSB +: CLUSTER_W] !== want.cluster)
            report($sformatf("start cluster %h, predicted %h",
                             d[RSP_CLUSTER_LSB +: CLUSTER_W], want.cluster));
         if (d[RSP_PROGRESS_LSB +: IDX_W] !== want.progress)
            report($sformatf("progress %0d, predicted %0d",
                             d[RSP_PROGRESS_LSB +: IDX_W], want.progress));
      endtask
   endclass

   match_scoreboard sb;

   // Response side: random stall, sample at the rising edge.
   always @(negedge clock)
      rsp_tready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);

   // Random helpers for stimulus.
   function automatic logic [ENTRY_W-1:0] random_entry();
      return {$urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   function automatic logic [ENTRY_W-1:0] gen_target(input bit want_long);
      logic [ENTRY_W-1:0] e;
      logic [BYTE_W-1:0] attr;
      e    = random_entry();
      attr = BYTE_W'($urandom_range(255));
      if (want_long)
         attr = LONG_ATTR;
      else if (attr == LONG_ATTR)
         attr = SHORT_ATTR;
      return put_octet(e, ATTR_BYTE, attr);
   endfunction

   // An entry that agrees with target t, with the free bytes randomized.
   function automatic logic [ENTRY_W-1:0] matching_entry(input logic [ENTRY_W-1:0] t);
      logic [ENTRY_W-1:0] e;
      bit t_long;
      e      = random_entry();
      t_long = is_long_entry(t);
      for (int k = 0; k < ENTRY_BYTES; k++)
         if (name_byte(k, t_long))
            e = put_octet(e, k, octet(t, k));
      if (t_long)
         e = put_octet(e, ATTR_BYTE, LONG_ATTR);
      else if (is_long_entry(e))
         e = put_octet(e, ATTR_BYTE, SHORT_ATTR);
      return e;
   endfunction

   // Break the name compare of an entry: flip its class or one name byte.
   function automatic logic [ENTRY_W-1:0] spoil(input logic [ENTRY_W-1:0] e);
      bit e_long;
      int k;
      e_long = is_long_entry(e);
      if ($urandom_range(4) == 0)
         return put_octet(e, ATTR_BYTE, e_long ? SHORT_ATTR : LONG_ATTR);
      do
         k = $urandom_range(ENTRY_BYTES - 1);
      while (!name_byte(k, e_long));
      return put_octet(e, k, octet(e, k) ^ BYTE_W'($urandom_range(255, 1)));
   endfunction

   function automatic logic [ENTRY_W-1:0] noise_entry();
      logic [ENTRY_W-1:0] e;
      int pick;
      pick = $urandom_range(9);
      e    = (pick == 0) ? '1 : (pick == 1) ? '0 : random_entry();
      if ($urandom_range(9) < 3)
         e = put_octet(e, ATTR_BYTE, LONG_ATTR);
      return e;
   endfunction

   // Drive one request transaction and wait for its acceptance.
   task automatic send_item(input logic [MODE_W-1:0] mode,
                            input logic [SLOT_W-1:0] slot,
                            input logic [ENTRY_W-1:0] entry);
      logic [REQ_TDATA_W-1:0] word;
      word = '0;
      word[REQ_SLOT_LSB +: SLOT_W]   = slot;
      word[REQ_ENTRY_LSB +: ENTRY_W] = entry;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = word;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_request(mode, slot, entry);
      if (mode == fdm_pkg::MODE_LOAD)
         target_image[slot] = entry;
      item_count++;
   endtask

   // Stop sending and wait until every owed response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the long entry count, then read it back.
   task automatic csr_write(input logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = LONG_COUNT_ADDR;
      csr_pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      sb.set_long_count(value);
      cur_count = value;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata[COUNT_W-1:0] !== value)
         sb.report($sformatf("count register reads %0d, written %0d",
                             csr_prdata[COUNT_W-1:0], value));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Field extremes, every mode, and the short and long hit paths.
   task automatic directed_items();
      logic [ENTRY_W-1:0] short_t, long_t, tail, e;
      short_t = gen_target(1'b0);
      send_item(fdm_pkg::MODE_LOAD, '0, short_t);
      send_item(fdm_pkg::MODE_SCAN, '0, matching_entry(short_t));
      send_item(fdm_pkg::MODE_SCAN, '1, '1);
      send_item(fdm_pkg::MODE_SCAN, '0, '0);
      send_item(MODE_NONE, '1, '1);
      send_item(fdm_pkg::MODE_LOAD, '1, '1);
      send_item(fdm_pkg::MODE_CLEAR, '1, '1);
      // A long entry never matches a short target.
      send_item(fdm_pkg::MODE_SCAN, '0, gen_target(1'b1));
      e = matching_entry(short_t);
      e = put_octet(put_octet(e, CLUSTER_HI_BYTE, '1), CLUSTER_HI_BYTE + 1, '1);
      e = put_octet(put_octet(e, CLUSTER_LO_BYTE, '1), CLUSTER_LO_BYTE + 1, '1);
      send_item(fdm_pkg::MODE_SCAN, '0, e);

      // One long target followed by its short entry.
      wait_drained();
      csr_write(COUNT_W'(1));
      long_t = gen_target(1'b1);
      tail   = gen_target(1'b0);
      send_item(fdm_pkg::MODE_LOAD, '0, long_t);
      send_item(fdm_pkg::MODE_SCAN, '0,
                put_octet(matching_entry(long_t), CHECKSUM_BYTE, short_name_sum(tail)));
      send_item(fdm_pkg::MODE_SCAN, '0, tail);
      // Checksum mismatch on the short entry.
      send_item(fdm_pkg::MODE_SCAN, '0,
                put_octet(matching_entry(long_t), CHECKSUM_BYTE, short_name_sum(tail)));
      send_item(fdm_pkg::MODE_SCAN, '0, put_octet(tail, 0, ~octet(tail, 0)));
      // A long entry in the checksum position carries its own sum.
      send_item(fdm_pkg::MODE_SCAN, '0, matching_entry(long_t));
      e = gen_target(1'b1);
      send_item(fdm_pkg::MODE_SCAN, '0, put_octet(e, CHECKSUM_BYTE, short_name_sum(e)));
      // Clear in the middle of a search.
      send_item(fdm_pkg::MODE_SCAN, '0, matching_entry(long_t));
      send_item(fdm_pkg::MODE_CLEAR, '0, '0);
      send_item(fdm_pkg::MODE_SCAN, '0, tail);
   endtask

   // Random searches under the current count, with noise in between.
   task automatic run_segment(input int budget);
      logic [ENTRY_W-1:0] tail, e;
      logic [BYTE_W-1:0] tail_sum;
      logic [MODE_W-1:0] mode;
      int first, eff, spoiled, burst;
      first = item_count;
      eff   = (int'(cur_count) > SLOT_COUNT) ? SLOT_COUNT : int'(cur_count);
      while (item_count - first < budget) begin
         if ($urandom_range(99) < 70) begin
            // Well-formed search, optionally over freshly loaded targets.
            if ($urandom_range(2) == 0) begin
               if (eff == 0)
                  send_item(fdm_pkg::MODE_LOAD, '0, gen_target($urandom_range(4) == 0));
               else
                  for (int i = 0; i < eff; i++)
                     send_item(fdm_pkg::MODE_LOAD, SLOT_W'(i),
                               gen_target($urandom_range(9) != 0));
            end
            if ($urandom_range(4) != 0)
               send_item(fdm_pkg::MODE_CLEAR, SLOT_W'($urandom_range(31)), noise_entry());
            tail     = gen_target($urandom_range(9) == 0);
            tail_sum = short_name_sum(tail);
            spoiled  = ($urandom_range(3) == 0) ? $urandom_range(eff) : -1;
            if (eff == 0) begin
               e = matching_entry(target_image[0]);
               send_item(fdm_pkg::MODE_SCAN, SLOT_W'($urandom_range(31)),
                         spoiled == 0 ? spoil(e) : e);
            end else begin
               for (int i = 0; i < eff; i++) begin
                  e = put_octet(matching_entry(target_image[i]), CHECKSUM_BYTE, tail_sum);
                  send_item(fdm_pkg::MODE_SCAN, SLOT_W'($urandom_range(31)),
                            i == spoiled ? spoil(e) : e);
               end
               if (spoiled == eff)
                  tail = put_octet(tail, 0, octet(tail, 0) ^ BYTE_W'($urandom_range(255, 1)));
               send_item(fdm_pkg::MODE_SCAN, SLOT_W'($urandom_range(31)), tail);
            end
            // Now and then the sender holds off until the block has caught up.
            if ($urandom_range(9) == 0)
               wait_drained();
         end else begin
            burst = $urandom_range(6, 1);
            for (int i = 0; i < burst; i++) begin
               mode = MODE_W'($urandom_range(3));
               send_item(mode, SLOT_W'($urandom_range(31)), noise_entry());
            end
         end
      end
   endtask

   function automatic logic [COUNT_W-1:0] pick_count(input int seg);
      case (seg)
         0: return '0;
         1: return COUNT_W'(SLOT_COUNT);
         2: return '1;
         3: return COUNT_W'(1);
         default: return ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(63))
                                                  : COUNT_W'($urandom_range(8));
      endcase
   endfunction

   // Main sequence.
   initial begin
      sb = new();
      foreach (target_image[i])
         target_image[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write('0);
      // Fill every slot so that no search ever reads an unwritten one.
      for (int s = 0; s < SLOT_COUNT; s++)
         send_item(fdm_pkg::MODE_LOAD, SLOT_W'(s), gen_target($urandom_range(1) == 1));
      directed_items();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_drained();
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         csr_write(pick_count(seg));
         run_segment(SEGMENT_SIZE);
      end

      wait_drained();
      if (sb.pending() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #TIMEOUT;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
